FILE: sv/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg: sorted list table shared types
// Command and status codes, sequencer states and the per-cell control struct.
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CountOutW = 6;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_IGNORE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_APPLY
  } state_e;

  typedef struct packed {
    logic                     eval;
    logic                     ins;
    logic                     del;
    logic signed [ValueW-1:0] value;
  } cell_ctrl_t;

endpackage

FILE: sv/slt_cell.sv
// ----------------------------------------------------------------------------
// slt_cell: one slot of the sorted list
// Holds one entry, compares it against the broadcast value and shifts
// toward its right or left neighbor on insert or delete.
// ----------------------------------------------------------------------------
module slt_cell #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned CntW = 6
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  slt_pkg::cell_ctrl_t             ctrl_i,
  input  logic [CntW-1:0]                 count_i,
  input  logic signed [slt_pkg::ValueW-1:0] left_entry_i,
  input  logic                            left_lt_i,
  input  logic signed [slt_pkg::ValueW-1:0] right_entry_i,
  output logic signed [slt_pkg::ValueW-1:0] entry_o,
  output logic                            lt_o,
  output logic                            eq_o
);
  import slt_pkg::*;

  localparam logic [CntW-1:0] IdxC = CntW'(Idx);

  logic signed [ValueW-1:0] entry_q, entry_d;
  logic                     lt_q, eq_q;
  logic                     occ;

  assign occ = IdxC < count_i;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (!lt_q) begin
        entry_d = left_lt_i ? ctrl_i.value : left_entry_i;
      end
    end else if (ctrl_i.del) begin
      if (!lt_q) begin
        entry_d = right_entry_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else if (ctrl_i.eval) begin
      lt_q <= occ && (entry_q < ctrl_i.value);
      eq_q <= occ && (entry_q == ctrl_i.value);
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign lt_o    = lt_q;
  assign eq_o    = eq_q;

endmodule

FILE: sv/sorted_list_table_core.sv
// ----------------------------------------------------------------------------
// sorted_list_table_core: sorted table of signed 32-bit values
// Row of compare-and-shift cells keeping entries in ascending order.
// ----------------------------------------------------------------------------
// Usage:
//   A request (cmd_i, value_i) is taken at a rising edge with start_i high
//   and busy_o low. Insert places the value ahead of the first entry that
//   is not smaller; delete removes the first equal entry and returns it;
//   search reports presence. An insert into a full table is dropped.
//   Each request gives one result on status_o, removed_value_o,
//   entry_count_o and is_empty_o, shown for exactly one cycle with done_o.
// Timing:
//   In S_EVAL every cell compares its entry with the value and latches the
//   flags; in S_APPLY the cells shift by one slot and the result registers
//   load; done_o is registered from S_APPLY. busy_o is high in S_EVAL and
//   S_APPLY, so a new request is taken only after the compare and shift
//   steps of the last one are through.
// Reset clears the entry count; entry contents stay undefined. The
// receiver cannot stall: a result not taken in its cycle is gone.
// ----------------------------------------------------------------------------
module sorted_list_table_core #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [1:0]                        cmd_i,
  input  logic signed [31:0]                value_i,
  output logic                              done_o,
  output logic [1:0]                        status_o,
  output logic signed [31:0]                removed_value_o,
  output logic [slt_pkg::CountOutW-1:0]     entry_count_o,
  output logic                              is_empty_o
);
  import slt_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CapC = CntW'(CAPACITY);

  state_e                   state_q, state_d;
  cmd_e                     cmd_q;
  logic signed [ValueW-1:0] value_q;
  logic [CntW-1:0]          count_q, count_d;
  logic                     done_q;
  status_e                  status_q, status_d;
  logic signed [ValueW-1:0] removed_q, removed_d;

  cell_ctrl_t               ctrl;
  logic signed [ValueW-1:0] entry [CAPACITY];
  logic [CAPACITY-1:0]      lt, eq;
  logic                     found, full, apply, ins_ok, del_ok, accept;

  assign accept = start_i && (state_q == S_IDLE);
  assign found  = |eq;
  assign full   = count_q == CapC;
  assign apply  = state_q == S_APPLY;
  assign ins_ok = apply && (cmd_q == CMD_INSERT) && !full;
  assign del_ok = apply && (cmd_q == CMD_DELETE) && found;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (start_i) state_d = S_EVAL;
      S_EVAL:  state_d = S_APPLY;
      S_APPLY: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy_o     = state_q != S_IDLE;
    ctrl.eval  = state_q == S_EVAL;
    ctrl.ins   = ins_ok;
    ctrl.del   = del_ok;
    ctrl.value = value_q;
  end

  always_comb begin
    count_d = count_q;
    if (ins_ok) begin
      count_d = count_q + CntW'(1);
    end else if (del_ok) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    removed_d = '0;
    unique case (cmd_q)
      CMD_INSERT: status_d = full ? ST_FULL : ST_OK;
      CMD_DELETE: begin
        status_d = found ? ST_OK : ST_NOT_FOUND;
        if (found) removed_d = value_q;
      end
      CMD_SEARCH: status_d = found ? ST_OK : ST_NOT_FOUND;
      default:    status_d = ST_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= apply;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_e'(cmd_i);
      value_q <= value_i;
    end
    if (apply) begin
      status_q  <= status_d;
      removed_q <= removed_d;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [ValueW-1:0] left_entry, right_entry;
    logic                     left_lt;

    if (i == 0) begin : g_first
      assign left_entry = value_q;
      assign left_lt    = 1'b1;
    end else begin : g_mid
      assign left_entry = entry[i-1];
      assign left_lt    = lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = entry[i];
    end else begin : g_inner
      assign right_entry = entry[i+1];
    end

    slt_cell #(
      .Idx  (i),
      .CntW (CntW)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .count_i       (count_q),
      .left_entry_i  (left_entry),
      .left_lt_i     (left_lt),
      .right_entry_i (right_entry),
      .entry_o       (entry[i]),
      .lt_o          (lt[i]),
      .eq_o          (eq[i])
    );
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign entry_count_o   = CountOutW'(count_q);
  assign is_empty_o      = count_q == '0;

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for sorted_list_table_core
// A table of directed requests runs first. It covers the empty table, the
// value extremes, duplicate values, the unused command, and inserts into a
// full table. Random fill and drain cycles follow, with most deletes and
// searches aimed at stored values. A shadow copy of the sorted table
// predicts every result that a typed directed row does not give itself.
// Each done_o strobe is compared field by field with the oldest pending
// prediction. The sender idles at random between requests.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import slt_pkg::*;

  localparam int unsigned CAPACITY     = 32;
  localparam int unsigned RANDOM_ITEMS = 600;
  localparam int unsigned IDLE_LIMIT   = 400;
  localparam int unsigned DRAIN_CYCLES = 10;

  localparam logic signed [ValueW-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [ValueW-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [ValueW-1:0] EXTREME_VALUES [6] = '{
    32'sh8000_0000, 32'sh8000_0001, 32'shffff_ffff,
    32'sh0000_0001, 32'sh7fff_fffe, 32'sh7fff_ffff
  };

  typedef struct packed {
    status_e                  status;
    logic signed [ValueW-1:0] removed;
    logic [CountOutW-1:0]     count;
    logic                     empty;
  } table_result_t;

  typedef struct packed {
    cmd_e                     cmd;
    logic signed [ValueW-1:0] value;
    logic [5:0]               reps;
    logic                     typed;
    table_result_t            res;
  } request_row_t;

  localparam int unsigned NUM_ROWS = 22;
  localparam request_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{CMD_SEARCH, 32'sd0,   6'd1,  1'b1, '{ST_NOT_FOUND, 32'sd0, 6'd0, 1'b1}},
    '{CMD_DELETE, 32'sd0,   6'd1,  1'b1, '{ST_NOT_FOUND, 32'sd0, 6'd0, 1'b1}},
    '{CMD_IGNORE, VAL_MAX,  6'd1,  1'b1, '{ST_OK, 32'sd0, 6'd0, 1'b1}},
    '{CMD_INSERT, VAL_MIN,  6'd1,  1'b1, '{ST_OK, 32'sd0, 6'd1, 1'b0}},
    '{CMD_INSERT, VAL_MAX,  6'd1,  1'b1, '{ST_OK, 32'sd0, 6'd2, 1'b0}},
    '{CMD_INSERT, 32'sd0,   6'd1,  1'b0, '{ST_OK, 32'sd0, 6'd0, 1'b0}},
    '{CMD_INSERT, 32'sd0,   6'd1,  1'b0, '{ST_OK, 32'sd0, 6'd0, 1'b0}},
    '{CMD_INSERT, -32'sd1,  6'd1,  1'b0, '{ST_OK, 32'sd0, 6'd0, 1'b0}},
    '{CMD_SEARCH, VAL_MAX,  6'd1,  1'b1, '{ST_OK, 32'sd0, 6'd5, 1'b0}},
    '{CMD_SEARCH, 32'sd5,   6'd1,  1'b1, '{ST_NOT_FOUND, 32'sd0, 6'd5, 1'b0}},
    '{CMD_DELETE, 32'sd0,   6'd1,  1'b0, '{ST_OK, 32'sd0, 6'd0, 1'b0}},
    '{CMD_DELETE, VAL_MIN,  6'd1,  1'b1, '{ST_OK, VAL_MIN, 6'd3, 1'b0}},
    '{CMD_DELETE, VAL_MAX,  6'd1,  1'b1, '{ST_OK, VAL_MAX, 6'd2, 1'b0}},
    '{CMD_IGNORE, VAL_MIN,  6'd1,  1'b0, '{ST_OK, 32'sd0, 6'd0, 1'b0}},
    '{CMD_INSERT, 32'sd100, 6'd30, 1'b0, '{ST_OK, 32'sd0, 6'd0, 1'b0}},
    '{CMD_INSERT, 32'sd7,   6'd1,  1'b1, '{ST_FULL, 32'sd0, 6'd32, 1'b0}},
    '{CMD_SEARCH, -32'sd1,  6'd1,  1'b0, '{ST_OK, 32'sd0, 6'd0, 1'b0}},
    '{CMD_DELETE, 32'sd0,   6'd1,  1'b0, '{ST_OK, 32'sd0, 6'd0, 1'b0}},
    '{CMD_INSERT, VAL_MIN,  6'd1,  1'b0, '{ST_OK, 32'sd0, 6'd0, 1'b0}},
    '{CMD_INSERT, VAL_MAX,  6'd1,  1'b1, '{ST_FULL, 32'sd0, 6'd32, 1'b0}},
    '{CMD_DELETE, 32'sd200, 6'd1,  1'b0, '{ST_OK, 32'sd0, 6'd0, 1'b0}},
    '{CMD_SEARCH, VAL_MIN,  6'd1,  1'b0, '{ST_OK, 32'sd0, 6'd0, 1'b0}}
  };

  logic                        clk_i   = 1'b0;
  logic                        rst_ni  = 1'b0;
  logic                        start_i = 1'b0;
  logic [1:0]                  cmd_i   = 2'd0;
  logic signed [ValueW-1:0]    value_i = '0;
  logic                        busy_o;
  logic                        done_o;
  logic [1:0]                  status_o;
  logic signed [ValueW-1:0]    removed_value_o;
  logic [CountOutW-1:0]        entry_count_o;
  logic                        is_empty_o;

  logic signed [ValueW-1:0]    shadow_table [CAPACITY];
  int unsigned                 shadow_count = 0;
  table_result_t               pending_results [$];
  int unsigned                 fail_count = 0;
  int unsigned                 idle_cycles = 0;
  int unsigned                 burst_left = 0;

  sorted_list_table_core #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cmd_i          (cmd_i),
    .value_i        (value_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .removed_value_o(removed_value_o),
    .entry_count_o  (entry_count_o),
    .is_empty_o     (is_empty_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int find_stored(logic signed [ValueW-1:0] v);
    for (int i = 0; i < shadow_count; i++) begin
      if (shadow_table[i] == v) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic table_result_t apply_table_command(cmd_e c, logic signed [ValueW-1:0] v);
    table_result_t r;
    int            pos;
    r.status  = ST_OK;
    r.removed = '0;
    case (c)
      CMD_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < shadow_count && shadow_table[pos] < v) pos++;
          for (int i = shadow_count; i > pos; i--) shadow_table[i] = shadow_table[i-1];
          shadow_table[pos] = v;
          shadow_count++;
        end
      end
      CMD_DELETE: begin
        pos = find_stored(v);
        if (pos < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.removed = shadow_table[pos];
          for (int i = pos; i + 1 < shadow_count; i++) shadow_table[i] = shadow_table[i+1];
          shadow_count--;
        end
      end
      CMD_SEARCH: begin
        if (find_stored(v) < 0) r.status = ST_NOT_FOUND;
      end
      default: begin
      end
    endcase
    r.count = CountOutW'(shadow_count);
    r.empty = (shadow_count == 0);
    return r;
  endfunction

  function automatic logic signed [ValueW-1:0] draw_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return ValueW'($urandom_range(0, 16)) - 8;
      4:          return EXTREME_VALUES[$urandom_range(0, 5)];
      default:    return $urandom;
    endcase
  endfunction

  // mostly random gaps, with occasional back-to-back bursts
  function automatic int unsigned draw_gap();
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst_left = 20;
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  task automatic issue_request(input cmd_e c, input logic signed [ValueW-1:0] v,
                               input int unsigned gap);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    cmd_i   <= c;
    value_i <= v;
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  task automatic wait_results_drained();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  initial begin
    table_result_t            want;
    logic signed [ValueW-1:0] v;
    cmd_e                     c;
    int unsigned              counted;
    int unsigned              sel;
    bit                       filling;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int row = 0; row < NUM_ROWS; row++) begin
      for (int rep = 0; rep < DIRECTED_ROWS[row].reps; rep++) begin
        v = DIRECTED_ROWS[row].value + ValueW'(rep);
        issue_request(DIRECTED_ROWS[row].cmd, v, draw_gap());
        want = apply_table_command(DIRECTED_ROWS[row].cmd, v);
        if (DIRECTED_ROWS[row].typed) want = DIRECTED_ROWS[row].res;
        pending_results.push_back(want);
      end
    end
    wait_results_drained();

    // alternate fill and drain phases so full and empty tables recur
    counted = 0;
    filling = 1'b1;
    while (counted < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 5) begin
        c = CMD_IGNORE;
      end else if (sel < 20) begin
        c = CMD_SEARCH;
      end else begin
        c = ((sel < 70) == filling) ? CMD_INSERT : CMD_DELETE;
      end
      if (c inside {CMD_DELETE, CMD_SEARCH} && shadow_count != 0 && $urandom_range(0, 3) != 0)
      begin
        v = shadow_table[$urandom_range(0, shadow_count - 1)];
      end else begin
        v = draw_value();
      end
      issue_request(c, v, draw_gap());
      pending_results.push_back(apply_table_command(c, v));
      if (shadow_count == CAPACITY && $urandom_range(0, 2) == 0) filling = 1'b0;
      if (shadow_count == 0) filling = 1'b1;
      counted++;
    end

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS sorted_list_table_core");
    end else begin
      $display("FAIL sorted_list_table_core");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    table_result_t want;
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result: status %0d removed %0d count %0d empty %0d",
                   $time, status_o, removed_value_o, entry_count_o, is_empty_o);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (status_o !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
            fail_count++;
          end
          if (removed_value_o !== want.removed) begin
            $display("%0t: removed_value expected %0d actual %0d",
                     $time, want.removed, removed_value_o);
            fail_count++;
          end
          if (entry_count_o !== want.count) begin
            $display("%0t: entry_count expected %0d actual %0d",
                     $time, want.count, entry_count_o);
            fail_count++;
          end
          if (is_empty_o !== want.empty) begin
            $display("%0t: is_empty expected %0d actual %0d", $time, want.empty, is_empty_o);
            fail_count++;
          end
        end
      end else if (done_o !== 1'b0) begin
        $display("%0t: done_o expected 0 or 1 actual %b", $time, done_o);
        fail_count++;
      end
      if ((start_i === 1'b1 && busy_o === 1'b0) || done_o === 1'b1) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    wait (rst_ni === 1'b1);
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("%0t: no request or result for %0d cycles", $time, IDLE_LIMIT);
    $display("FAIL sorted_list_table_core");
    $finish;
  end

endmodule
